### rtl/core/assert_macros.svh
// assertion macros for the rtl files of the witness check block
// no dependencies; expects signals clk and rst in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/mrwc_pkg.sv
// package for the miller-rabin witness check block
// holds default widths and the output bus width; no dependencies
`default_nettype none

package mrwc_pkg;

  localparam int DEFAULT_NUM_WIDTH = 16;
  localparam int OUT_TDATA_W       = 8;

endpackage

`default_nettype wire

### rtl/core/miller_rabin_witness_check.sv
// top level of the miller-rabin witness check block
// depends on mrwc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// One Miller-Rabin round per request: number n and base a come in on the s_ side, one bit
// composite comes out on the m_ side. All arithmetic runs through a single modular
// multiplier that handles one multiplier bit per cycle. A request splits n-1 into u*2^t,
// takes one product to reduce the base, up to two products per bit of u, and up to t-1
// more squarings. The input is taken only while the sequencer is idle; a result waiting
// on the output does not block the next request. Numbers 0, 1 and 2 go straight to the
// output state without any product.
module miller_rabin_witness_check #(
  parameter int NUM_WIDTH = mrwc_pkg::DEFAULT_NUM_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // number, base, zero padding
  input  logic [((2*NUM_WIDTH+7)/8)*8-1:0]      s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // composite, zero padding
  output logic [mrwc_pkg::OUT_TDATA_W-1:0]      m_tdata
);

  localparam int W  = NUM_WIDTH;
  localparam int TW = $clog2(W);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SPLIT = 6'b000010,
    S_MUL   = 6'b000100,
    S_POW   = 6'b001000,
    S_CHECK = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t          state;
  state_t          ret;
  logic [W-1:0]    num;
  logic [W-1:0]    base;
  logic [W-1:0]    n;
  logic [W-1:0]    n_m1;
  logic [W-1:0]    u;
  logic [TW-1:0]   t_cnt;
  logic [W-1:0]    acc;
  logic [W-1:0]    sq;
  logic [W-1:0]    mx;
  logic [W-1:0]    my;
  logic [W-1:0]    r;
  logic [W-1:0]    r_next;
  logic [TW-1:0]   bit_idx;
  logic            dest_sq;
  logic            phase;
  logic            first;
  logic            res;
  logic            composite;
  logic [W:0]      dbl;
  logic [W:0]      dbl_red;
  logic [W-1:0]    dbl_mod;
  logic [W:0]      sum;
  logic [W:0]      sum_red;

  assign num      = s_tdata[W-1:0];
  assign base     = s_tdata[2*W-1:W];
  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {{(mrwc_pkg::OUT_TDATA_W-1){1'b0}}, composite};
  assign n_m1     = n - W'(1);

  // shared modular multiply step: r = 2r + bit*mx mod n
  always_comb begin
    dbl     = {r, 1'b0};
    dbl_red = dbl - {1'b0, n};
    dbl_mod = (dbl >= {1'b0, n}) ? dbl_red[W-1:0] : dbl[W-1:0];
    sum     = {1'b0, dbl_mod} + (my[W-1] ? {1'b0, mx} : '0);
    sum_red = sum - {1'b0, n};
    r_next  = (sum >= {1'b0, n}) ? sum_red[W-1:0] : sum[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            n     <= num;
            u     <= num - W'(1);
            t_cnt <= '0;
            acc   <= W'(1);
            phase <= 1'b0;
            first <= 1'b1;
            if (num < W'(2)) begin
              res   <= 1'b1;
              state <= S_FIN;
            end else if (num == W'(2)) begin
              res   <= 1'b0;
              state <= S_FIN;
            end else begin
              // reduce the base: 1 * base mod n
              mx      <= W'(1);
              my      <= base;
              r       <= '0;
              bit_idx <= TW'(W-1);
              dest_sq <= 1'b1;
              ret     <= S_SPLIT;
              state   <= S_MUL;
            end
          end
        end
        S_SPLIT: begin
          if (!u[0]) begin
            u     <= {1'b0, u[W-1:1]};
            t_cnt <= t_cnt + TW'(1);
          end else begin
            state <= S_POW;
          end
        end
        S_MUL: begin
          r  <= r_next;
          my <= {my[W-2:0], 1'b0};
          if (bit_idx == '0) begin
            if (dest_sq) begin
              sq <= r_next;
            end else begin
              acc <= r_next;
            end
            state <= ret;
          end else begin
            bit_idx <= bit_idx - TW'(1);
          end
        end
        S_POW: begin
          if (u == '0) begin
            state <= S_CHECK;
          end else if (!phase) begin
            phase <= 1'b1;
            if (u[0]) begin
              mx      <= acc;
              my      <= sq;
              r       <= '0;
              bit_idx <= TW'(W-1);
              dest_sq <= 1'b0;
              ret     <= S_POW;
              state   <= S_MUL;
            end
          end else begin
            phase <= 1'b0;
            u     <= {1'b0, u[W-1:1]};
            if (u[W-1:1] != '0) begin
              mx      <= sq;
              my      <= sq;
              r       <= '0;
              bit_idx <= TW'(W-1);
              dest_sq <= 1'b1;
              ret     <= S_POW;
              state   <= S_MUL;
            end
          end
        end
        S_CHECK: begin
          if ((first && acc == W'(1)) || acc == n_m1) begin
            res   <= 1'b0;
            state <= S_FIN;
          end else if (t_cnt <= TW'(1)) begin
            res   <= 1'b1;
            state <= S_FIN;
          end else begin
            // one more squaring of x
            t_cnt   <= t_cnt - TW'(1);
            first   <= 1'b0;
            mx      <= acc;
            my      <= acc;
            r       <= '0;
            bit_idx <= TW'(W-1);
            dest_sq <= 1'b0;
            ret     <= S_CHECK;
            state   <= S_MUL;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            composite <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_rem_below_mod, (state == S_MUL) |-> (r < n), "partial remainder not below n")
  `ASSERT_CLK(a_ops_below_mod, (state == S_POW || state == S_CHECK) |-> (acc < n && sq < n),
              "operand not reduced modulo n")
  `ASSERT_CLK(a_two_is_prime, (s_tvalid && s_tready && num == W'(2)) |=> (state == S_FIN && !res),
              "number two not flagged prime")
  `ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && !m_tvalid),
                 "not idle after reset")

endmodule

`default_nettype wire
